[rtl/ecrd_pkg.sv]
// ----------------------------------------------------------------------------
// ecrd_pkg
// Shared types and constants of the event counter / round-robin dispatcher.
// ----------------------------------------------------------------------------
package ecrd_pkg;

    localparam int LINE_W   = 8;
    localparam int ADDR_W   = 12;
    localparam int DATA_W   = 32;
    localparam int WORDS    = 8;
    localparam int WIDX_W   = 3;
    localparam int FWD_CNT_W = 7;
    localparam int FWD_IDX_W = 6;
    localparam int FWD_DEPTH = 64;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [ADDR_W-1:0] A_SOFT   = 12'h000;
    localparam logic [ADDR_W-1:0] A_CM_LO  = 12'h004;
    localparam logic [ADDR_W-1:0] A_CM_HI  = 12'h020;
    localparam logic [ADDR_W-1:0] A_PM_LO  = 12'h044;
    localparam logic [ADDR_W-1:0] A_PM_HI  = 12'h060;
    localparam logic [ADDR_W-1:0] A_ERR_LO = 12'h064;
    localparam logic [ADDR_W-1:0] A_ERR_HI = 12'h080;
    localparam logic [ADDR_W-1:0] A_TLO    = 12'h084;
    localparam logic [ADDR_W-1:0] A_THI    = 12'h088;
    localparam logic [ADDR_W-1:0] A_FIFO   = 12'h090;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EVENT,
        OP_WR_SOFT,
        OP_WR_CMASK,
        OP_WR_PMASK,
        OP_WR_TLO,
        OP_WR_THI,
        OP_RD_SOFT,
        OP_RD_CMASK,
        OP_RD_PMASK,
        OP_RD_ERR,
        OP_RD_TLO,
        OP_RD_THI,
        OP_RD_FIFO
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [WIDX_W-1:0]  widx;
        logic [LINE_W-1:0]  line;
        logic               level;
        logic [DATA_W-1:0]  wdata;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SOFT,
        S_CNT_RD,
        S_CNT_UPD,
        S_SCAN_START,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

endpackage

[rtl/ecrd_req_if.sv]
// ----------------------------------------------------------------------------
// ecrd_req_if
// Request channel: event line changes and bus accesses.
// ----------------------------------------------------------------------------
interface ecrd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  event_line;
    logic        level;
    logic [11:0] address;
    logic [31:0] write_data;

    modport source (output valid, kind, event_line, level, address, write_data,
                    input ready);
    modport sink   (input valid, kind, event_line, level, address, write_data,
                    output ready);
endinterface

[rtl/ecrd_rsp_if.sv]
// ----------------------------------------------------------------------------
// ecrd_rsp_if
// Result channel: read data, interrupt levels and forwarded events.
// ----------------------------------------------------------------------------
interface ecrd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        fc_irq;
    logic        err_irq;
    logic        timer_lo_hit;
    logic        timer_hi_hit;
    logic        periph_valid;
    logic [7:0]  periph_event;
    logic        periph_overflow;
    logic        last;

    modport source (output valid, read_data, fc_irq, err_irq, timer_lo_hit,
                    timer_hi_hit, periph_valid, periph_event, periph_overflow,
                    last, input ready);
    modport sink   (input valid, read_data, fc_irq, err_irq, timer_lo_hit,
                    timer_hi_hit, periph_valid, periph_event, periph_overflow,
                    last, output ready);
endinterface

[rtl/ecrd_ram.sv]
// ----------------------------------------------------------------------------
// ecrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/ecrd_front.sv]
// ----------------------------------------------------------------------------
// ecrd_front
// Accepts requests, decodes them into commands and queues two of them.
// ----------------------------------------------------------------------------
module ecrd_front #(
    parameter int EVENT_LINES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    ecrd_req_if.sink         req,
    output ecrd_pkg::cmd_t   cmd,
    output logic             cmd_valid,
    input  logic             cmd_ready
);

    ecrd_pkg::cmd_t   dec;
    ecrd_pkg::cmd_t   q_reg [2];
    logic             rd_ptr_reg, rd_ptr_next;
    logic             wr_ptr_reg, wr_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;
    logic [ecrd_pkg::ADDR_W-1:0] a;

    assign a = req.address;

    always_comb
    begin
        dec.op    = ecrd_pkg::OP_NONE;
        dec.widx  = '0;
        dec.line  = req.event_line;
        dec.level = req.level;
        dec.wdata = req.write_data;
        unique case (req.kind)
            ecrd_pkg::KIND_EVENT:
            begin
                if (9'(req.event_line) < 9'(EVENT_LINES))
                begin
                    dec.op = ecrd_pkg::OP_EVENT;
                end
            end
            ecrd_pkg::KIND_WRITE, ecrd_pkg::KIND_READ:
            begin
                if (a == ecrd_pkg::A_SOFT)
                begin
                    dec.op = (req.kind == ecrd_pkg::KIND_WRITE) ?
                             ecrd_pkg::OP_WR_SOFT : ecrd_pkg::OP_RD_SOFT;
                end
                else if (a >= ecrd_pkg::A_CM_LO && a <= ecrd_pkg::A_CM_HI)
                begin
                    dec.widx = 3'((a - ecrd_pkg::A_CM_LO) >> 2);
                    dec.op   = (req.kind == ecrd_pkg::KIND_WRITE) ?
                               ecrd_pkg::OP_WR_CMASK : ecrd_pkg::OP_RD_CMASK;
                end
                else if (a >= ecrd_pkg::A_PM_LO && a <= ecrd_pkg::A_PM_HI)
                begin
                    dec.widx = 3'((a - ecrd_pkg::A_PM_LO) >> 2);
                    dec.op   = (req.kind == ecrd_pkg::KIND_WRITE) ?
                               ecrd_pkg::OP_WR_PMASK : ecrd_pkg::OP_RD_PMASK;
                end
                else if (a >= ecrd_pkg::A_ERR_LO && a <= ecrd_pkg::A_ERR_HI)
                begin
                    dec.widx = 3'((a - ecrd_pkg::A_ERR_LO) >> 2);
                    if (req.kind == ecrd_pkg::KIND_READ)
                    begin
                        dec.op = ecrd_pkg::OP_RD_ERR;
                    end
                end
                else if (a == ecrd_pkg::A_TLO)
                begin
                    dec.op = (req.kind == ecrd_pkg::KIND_WRITE) ?
                             ecrd_pkg::OP_WR_TLO : ecrd_pkg::OP_RD_TLO;
                end
                else if (a == ecrd_pkg::A_THI)
                begin
                    dec.op = (req.kind == ecrd_pkg::KIND_WRITE) ?
                             ecrd_pkg::OP_WR_THI : ecrd_pkg::OP_RD_THI;
                end
                else if (a == ecrd_pkg::A_FIFO && req.kind == ecrd_pkg::KIND_READ)
                begin
                    dec.op = ecrd_pkg::OP_RD_FIFO;
                end
            end
            default:
            begin
                dec.op = ecrd_pkg::OP_NONE;
            end
        endcase
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[rtl/ecrd_back.sv]
// ----------------------------------------------------------------------------
// ecrd_back
// Executes commands: counter updates, register access, round-robin scan,
// then emits the forwarded events and the final result.
// ----------------------------------------------------------------------------
module ecrd_back #(
    parameter int EVENT_LINES         = 256,
    parameter int SOFT_EVENT_BASE     = 160,
    parameter int MAX_PERIPH_PER_ITEM = 63
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ecrd_pkg::cmd_t   cmd,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    ecrd_rsp_if.source       rsp
);

    localparam int IDX_W = $clog2(EVENT_LINES);
    localparam logic [7:0] LAST_LINE = 8'(EVENT_LINES - 1);

    ecrd_pkg::state_t state_reg, state_next;
    ecrd_pkg::cmd_t   cmd_reg, cmd_next;

    logic [EVENT_LINES-1:0] nz_reg, nz_next;
    logic [7:0][31:0] cmask_reg, cmask_next;
    logic [7:0][31:0] pmask_reg, pmask_next;
    logic [7:0][31:0] err_reg, err_next;
    logic [7:0] tlo_reg, tlo_next, thi_reg, thi_next, soft_reg, soft_next;
    logic [7:0] pos_reg, pos_next;
    logic       ready_reg, ready_next, irq_reg, irq_next;

    logic [7:0] cur_reg, cur_next, line_reg, line_next;
    logic       dec_reg, dec_next, soft_act_reg, soft_act_next;
    logic [3:0] soft_i_reg, soft_i_next;
    logic [ecrd_pkg::FWD_CNT_W-1:0] fcnt_reg, fcnt_next, eidx_reg, eidx_next;
    logic       over_reg, over_next, hlo_reg, hlo_next, hhi_reg, hhi_next;
    logic [31:0] rdata_reg, rdata_next;

    logic        ov_reg, ov_next;
    logic [31:0] o_rdata_reg, o_rdata_next;
    logic        o_irq_reg, o_irq_next, o_err_reg, o_err_next;
    logic        o_hlo_reg, o_hlo_next, o_hhi_reg, o_hhi_next;
    logic        o_pv_reg, o_pv_next, o_ovf_reg, o_ovf_next, o_last_reg, o_last_next;
    logic [7:0]  o_ev_reg, o_ev_next;

    logic        cnt_we;
    logic [7:0]  cnt_wd, cnt_rd, cnt_cur, cnt_new;
    logic        fwd_we;
    logic [7:0]  fwd_rd;
    logic [8:0]  soft_line;
    logic        out_free, scan_hit;
    logic [4:0]  lb;
    logic [2:0]  lw;

    ecrd_ram #(.WIDTH(8), .DEPTH(EVENT_LINES)) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cur_reg[IDX_W-1:0]),
        .wr_data (cnt_wd),
        .rd_addr (cur_reg[IDX_W-1:0]),
        .rd_data (cnt_rd)
    );

    ecrd_ram #(.WIDTH(8), .DEPTH(ecrd_pkg::FWD_DEPTH)) u_fwd_ram (
        .clk     (clk),
        .wr_en   (fwd_we),
        .wr_addr (fcnt_reg[ecrd_pkg::FWD_IDX_W-1:0]),
        .wr_data (line_reg),
        .rd_addr (eidx_reg[ecrd_pkg::FWD_IDX_W-1:0]),
        .rd_data (fwd_rd)
    );

    assign out_free  = !ov_reg || rsp.ready;
    assign cmd_ready = (state_reg == ecrd_pkg::S_IDLE);
    assign soft_line = 9'(SOFT_EVENT_BASE) + 9'(soft_i_reg[2:0]);
    assign cnt_cur   = nz_reg[cur_reg[IDX_W-1:0]] ? cnt_rd : 8'd0;
    assign cnt_new   = dec_reg ? cnt_cur - 8'd1 : cnt_cur + 8'd1;
    assign scan_hit  = nz_reg[line_reg[IDX_W-1:0]];
    assign lb        = line_reg[4:0];
    assign lw        = line_reg[7:5];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ecrd_pkg::S_IDLE:
                if (cmd_valid) state_next = ecrd_pkg::S_EXEC;
            ecrd_pkg::S_EXEC:
            begin
                unique case (cmd_reg.op)
                    ecrd_pkg::OP_EVENT:
                        state_next = cmd_reg.level ? ecrd_pkg::S_CNT_RD
                                                   : ecrd_pkg::S_SCAN_START;
                    ecrd_pkg::OP_WR_SOFT: state_next = ecrd_pkg::S_SOFT;
                    ecrd_pkg::OP_RD_FIFO: state_next = ecrd_pkg::S_CNT_RD;
                    default:              state_next = ecrd_pkg::S_EMIT_RD;
                endcase
            end
            ecrd_pkg::S_SOFT:
            begin
                if (soft_i_reg[3])
                    state_next = ecrd_pkg::S_EMIT_RD;
                else if (cmd_reg.wdata[soft_i_reg[2:0]] &&
                         soft_line < 9'(EVENT_LINES))
                    state_next = ecrd_pkg::S_CNT_RD;
            end
            ecrd_pkg::S_CNT_RD:     state_next = ecrd_pkg::S_CNT_UPD;
            ecrd_pkg::S_CNT_UPD:    state_next = ecrd_pkg::S_SCAN_START;
            ecrd_pkg::S_SCAN_START:
            begin
                if (ready_reg)
                    state_next = ecrd_pkg::S_SCAN;
                else
                    state_next = soft_act_reg ? ecrd_pkg::S_SOFT : ecrd_pkg::S_EMIT_RD;
            end
            ecrd_pkg::S_SCAN:
            begin
                if ((scan_hit && !cmask_reg[lw][lb]) || line_reg == pos_reg)
                    state_next = soft_act_reg ? ecrd_pkg::S_SOFT : ecrd_pkg::S_EMIT_RD;
            end
            ecrd_pkg::S_EMIT_RD:    state_next = ecrd_pkg::S_EMIT_LD;
            ecrd_pkg::S_EMIT_LD:
            begin
                if (out_free)
                    state_next = (eidx_reg == fcnt_reg) ? ecrd_pkg::S_IDLE
                                                        : ecrd_pkg::S_EMIT_RD;
            end
            default: state_next = ecrd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        nz_next = nz_reg; cmask_next = cmask_reg; pmask_next = pmask_reg;
        err_next = err_reg; tlo_next = tlo_reg; thi_next = thi_reg;
        soft_next = soft_reg; pos_next = pos_reg;
        ready_next = ready_reg; irq_next = irq_reg;
        cur_next = cur_reg; line_next = line_reg; dec_next = dec_reg;
        soft_act_next = soft_act_reg; soft_i_next = soft_i_reg;
        fcnt_next = fcnt_reg; eidx_next = eidx_reg; over_next = over_reg;
        hlo_next = hlo_reg; hhi_next = hhi_reg; rdata_next = rdata_reg;
        ov_next = ov_reg && !rsp.ready;
        o_rdata_next = o_rdata_reg; o_irq_next = o_irq_reg; o_err_next = o_err_reg;
        o_hlo_next = o_hlo_reg; o_hhi_next = o_hhi_reg; o_pv_next = o_pv_reg;
        o_ovf_next = o_ovf_reg; o_last_next = o_last_reg; o_ev_next = o_ev_reg;
        cnt_we = 1'b0; cnt_wd = cnt_new; fwd_we = 1'b0;

        unique case (state_reg)
            ecrd_pkg::S_IDLE:
            begin
                if (cmd_valid)
                    cmd_next = cmd;
            end
            ecrd_pkg::S_EXEC:
            begin
                fcnt_next = '0; eidx_next = '0; over_next = 1'b0;
                hlo_next = 1'b0; hhi_next = 1'b0; rdata_next = '0;
                soft_act_next = 1'b0; dec_next = 1'b0;
                cur_next = cmd_reg.line;
                unique case (cmd_reg.op)
                    ecrd_pkg::OP_WR_SOFT:
                    begin
                        soft_next = cmd_reg.wdata[7:0];
                        soft_act_next = 1'b1;
                        soft_i_next = '0;
                    end
                    ecrd_pkg::OP_WR_CMASK: cmask_next[cmd_reg.widx] = cmd_reg.wdata;
                    ecrd_pkg::OP_WR_PMASK: pmask_next[cmd_reg.widx] = cmd_reg.wdata;
                    ecrd_pkg::OP_WR_TLO:   tlo_next = cmd_reg.wdata[7:0];
                    ecrd_pkg::OP_WR_THI:   thi_next = cmd_reg.wdata[7:0];
                    ecrd_pkg::OP_RD_SOFT:  rdata_next = 32'(soft_reg);
                    ecrd_pkg::OP_RD_CMASK: rdata_next = cmask_reg[cmd_reg.widx];
                    ecrd_pkg::OP_RD_PMASK: rdata_next = pmask_reg[cmd_reg.widx];
                    ecrd_pkg::OP_RD_ERR:
                    begin
                        rdata_next = err_reg[cmd_reg.widx];
                        err_next[cmd_reg.widx] = '0;
                    end
                    ecrd_pkg::OP_RD_TLO:   rdata_next = 32'(tlo_reg);
                    ecrd_pkg::OP_RD_THI:   rdata_next = 32'(thi_reg);
                    ecrd_pkg::OP_RD_FIFO:
                    begin
                        rdata_next = 32'(pos_reg);
                        irq_next = 1'b0;
                        err_next[pos_reg[7:5]][pos_reg[4:0]] = 1'b0;
                        ready_next = 1'b1;
                        cur_next = pos_reg;
                        dec_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            ecrd_pkg::S_SOFT:
            begin
                if (!soft_i_reg[3])
                begin
                    soft_i_next = soft_i_reg + 4'd1;
                    cur_next = soft_line[7:0];
                end
            end
            ecrd_pkg::S_CNT_UPD:
            begin
                cnt_we = 1'b1;
                nz_next[cur_reg[IDX_W-1:0]] = (cnt_new != 8'd0);
                if (!dec_reg)
                begin
                    if (cnt_cur == 8'd3)
                        err_next[cur_reg[7:5]][cur_reg[4:0]] = 1'b1;
                    if (cur_reg == tlo_reg) hlo_next = 1'b1;
                    if (cur_reg == thi_reg) hhi_next = 1'b1;
                end
            end
            ecrd_pkg::S_SCAN_START:
                line_next = (pos_reg >= LAST_LINE) ? 8'd0 : pos_reg + 8'd1;
            ecrd_pkg::S_SCAN:
            begin
                line_next = (line_reg >= LAST_LINE) ? 8'd0 : line_reg + 8'd1;
                if (scan_hit && !pmask_reg[lw][lb])
                begin
                    if (fcnt_reg < 7'(MAX_PERIPH_PER_ITEM) && fcnt_reg < 7'd63)
                    begin
                        fwd_we = 1'b1;
                        fcnt_next = fcnt_reg + 7'd1;
                    end
                    else
                        over_next = 1'b1;
                end
                if (scan_hit && !cmask_reg[lw][lb])
                begin
                    ready_next = 1'b0;
                    pos_next = line_reg;
                    irq_next = 1'b1;
                end
            end
            ecrd_pkg::S_EMIT_LD:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    o_rdata_next = rdata_reg;
                    o_irq_next = irq_reg;
                    o_err_next = |err_reg;
                    o_hlo_next = hlo_reg;
                    o_hhi_next = hhi_reg;
                    o_ovf_next = over_reg;
                    o_pv_next = (eidx_reg != fcnt_reg);
                    o_last_next = (eidx_reg == fcnt_reg);
                    o_ev_next = (eidx_reg != fcnt_reg) ? fwd_rd : 8'd0;
                    eidx_next = eidx_reg + 7'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        cur_reg <= cur_next; line_reg <= line_next; dec_reg <= dec_next;
        soft_i_reg <= soft_i_next; fcnt_reg <= fcnt_next; eidx_reg <= eidx_next;
        over_reg <= over_next; hlo_reg <= hlo_next; hhi_reg <= hhi_next;
        rdata_reg <= rdata_next; soft_act_reg <= soft_act_next;
        o_rdata_reg <= o_rdata_next; o_irq_reg <= o_irq_next; o_err_reg <= o_err_next;
        o_hlo_reg <= o_hlo_next; o_hhi_reg <= o_hhi_next; o_pv_reg <= o_pv_next;
        o_ovf_reg <= o_ovf_next; o_last_reg <= o_last_next; o_ev_reg <= o_ev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecrd_pkg::S_IDLE;
            nz_reg    <= '0;
            cmask_reg <= '1;
            pmask_reg <= '1;
            err_reg   <= '0;
            tlo_reg   <= 8'hFF;
            thi_reg   <= 8'hFF;
            soft_reg  <= '0;
            pos_reg   <= '0;
            ready_reg <= 1'b1;
            irq_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nz_reg    <= nz_next;
            cmask_reg <= cmask_next;
            pmask_reg <= pmask_next;
            err_reg   <= err_next;
            tlo_reg   <= tlo_next;
            thi_reg   <= thi_next;
            soft_reg  <= soft_next;
            pos_reg   <= pos_next;
            ready_reg <= ready_next;
            irq_reg   <= irq_next;
            ov_reg    <= ov_next;
        end
    end

    assign rsp.valid           = ov_reg;
    assign rsp.read_data       = o_rdata_reg;
    assign rsp.fc_irq          = o_irq_reg;
    assign rsp.err_irq         = o_err_reg;
    assign rsp.timer_lo_hit    = o_hlo_reg;
    assign rsp.timer_hi_hit    = o_hhi_reg;
    assign rsp.periph_valid    = o_pv_reg;
    assign rsp.periph_event    = o_ev_reg;
    assign rsp.periph_overflow = o_ovf_reg;
    assign rsp.last            = o_last_reg;

endmodule

[rtl/event_counter_round_robin_dispatch.sv]
// ----------------------------------------------------------------------------
// event_counter_round_robin_dispatch
// Event counters per line with round-robin dispatch to a controller and to
// peripherals; register file reached through bus requests.
//
// Channels: req carries event line changes, register writes and register
// reads; rsp returns, per request, the forwarded peripheral events in scan
// order (last = 0) followed by one final result (last = 1).
// Sequence: a request waits in the two-entry command queue, then the executor
// decodes it, reads and updates the counter (S_CNT_RD, S_CNT_UPD), starts a
// scan and scans one line after another (up to EVENT_LINES; a soft event
// write makes up to eight scans), then reads and loads each result
// (S_EMIT_RD, S_EMIT_LD).
// Requests are carried out one at a time, so the scan sets the throughput.
// Reset: counters zero, masks all ones, timer lines 255, controller ready,
// interrupts low; the block takes requests as soon as reset is released.
// A stalled receiver holds the current result; the queue keeps taking up to
// two requests meanwhile.
// ----------------------------------------------------------------------------
module event_counter_round_robin_dispatch #(
    parameter int EVENT_LINES         = 256,
    parameter int SOFT_EVENT_BASE     = 160,
    parameter int MAX_PERIPH_PER_ITEM = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    ecrd_req_if.sink    req,
    ecrd_rsp_if.source  rsp
);

    ecrd_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_ready;

    ecrd_front #(.EVENT_LINES(EVENT_LINES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    ecrd_back #(
        .EVENT_LINES         (EVENT_LINES),
        .SOFT_EVENT_BASE     (SOFT_EVENT_BASE),
        .MAX_PERIPH_PER_ITEM (MAX_PERIPH_PER_ITEM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );

endmodule

[bench/ecrd_tb_if.sv]
// ----------------------------------------------------------------------------
// ecrd_tb_if
// Clock and reset bundle of the bench.
// ----------------------------------------------------------------------------
interface ecrd_tb_clk_if (input logic clk);
    logic rst_n;
endinterface

[bench/event_counter_round_robin_dispatch_test.sv]
// ----------------------------------------------------------------------------
// event_counter_round_robin_dispatch_test
// Drives event arrivals and bus accesses into the dispatcher, predicts every
// result from a behavioral model of counters, masks and the round-robin
// scan, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module event_counter_round_robin_dispatch_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fc_irq;
        logic        err_irq;
        logic        timer_lo_hit;
        logic        timer_hi_hit;
        logic        periph_valid;
        logic [7:0]  periph_event;
        logic        periph_overflow;
        logic        last;
    } result_t;

    localparam int NLINES   = 256;
    localparam int SOFTBASE = 160;
    localparam int FWD_CAP  = 63;
    localparam logic [1:0] KIND_BAD = 2'd3;

    logic clk;
    ecrd_tb_clk_if sys (.clk(clk));
    ecrd_req_if req ();
    ecrd_rsp_if rsp ();

    event_counter_round_robin_dispatch uut (
        .clk   (clk),
        .rst_n (sys.rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor state
    logic [7:0]  cnt [NLINES];
    logic [31:0] cmask [8];
    logic [31:0] pmask [8];
    logic [31:0] errw [8];
    logic [7:0]  tlo_line;
    logic [7:0]  thi_line;
    logic [7:0]  soft_reg;
    logic [7:0]  scan_pos;
    logic        ctl_ready;
    logic        fc_level;
    logic [7:0]  fwd_lines [$];
    logic        fwd_over;
    logic        hit_lo;
    logic        hit_hi;

    result_t expected_results [$];
    int      mismatches;
    bit      rsp_stall_on;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void model_reset();
        for (int i = 0; i < NLINES; i++)
            cnt[i] = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            cmask[i] = 32'hFFFFFFFF;
            pmask[i] = 32'hFFFFFFFF;
            errw[i]  = 32'd0;
        end
        tlo_line = 8'hFF;
        thi_line = 8'hFF;
        soft_reg = 8'd0;
        scan_pos = 8'd0;
        ctl_ready = 1'b1;
        fc_level = 1'b0;
    endfunction

    function automatic void model_scan();
        logic [7:0] ln;
        if (!ctl_ready)
            return;
        ln = scan_pos + 8'd1;
        for (int k = 0; k < NLINES; k++)
        begin
            if (cnt[ln] != 8'd0)
            begin
                if (!pmask[ln[7:5]][ln[4:0]])
                begin
                    if (fwd_lines.size() < FWD_CAP)
                        fwd_lines.push_back(ln);
                    else
                        fwd_over = 1'b1;
                end
                if (!cmask[ln[7:5]][ln[4:0]])
                begin
                    ctl_ready = 1'b0;
                    scan_pos = ln;
                    fc_level = 1'b1;
                    return;
                end
            end
            if (ln == scan_pos)
                return;
            ln = ln + 8'd1;
        end
    endfunction

    function automatic void model_arrive(input logic [7:0] ln, input logic lvl);
        if (lvl)
        begin
            if (cnt[ln] == 8'd3)
                errw[ln[7:5]][ln[4:0]] = 1'b1;
            if (ln == tlo_line)
                hit_lo = 1'b1;
            if (ln == thi_line)
                hit_hi = 1'b1;
            cnt[ln] = cnt[ln] + 8'd1;
        end
        model_scan();
    endfunction

    function automatic logic [31:0] model_access(input logic [1:0] kind, input logic [7:0] ln,
                                                 input logic lvl, input logic [11:0] a,
                                                 input logic [31:0] wd);
        logic [31:0] v;
        logic [2:0]  w;
        v = 32'd0;
        if (kind == ecrd_pkg::KIND_EVENT)
            model_arrive(ln, lvl);
        else if (kind == ecrd_pkg::KIND_WRITE)
        begin
            if (a == ecrd_pkg::A_SOFT)
            begin
                soft_reg = wd[7:0];
                for (int i = 0; i < 8; i++)
                    if (wd[i])
                        model_arrive(8'(SOFTBASE + i), 1'b1);
            end
            else if (a >= ecrd_pkg::A_CM_LO && a <= ecrd_pkg::A_CM_HI)
            begin
                w = 3'((a - ecrd_pkg::A_CM_LO) >> 2);
                cmask[w] = wd;
            end
            else if (a >= ecrd_pkg::A_PM_LO && a <= ecrd_pkg::A_PM_HI)
            begin
                w = 3'((a - ecrd_pkg::A_PM_LO) >> 2);
                pmask[w] = wd;
            end
            else if (a == ecrd_pkg::A_TLO)
                tlo_line = wd[7:0];
            else if (a == ecrd_pkg::A_THI)
                thi_line = wd[7:0];
        end
        else if (kind == ecrd_pkg::KIND_READ)
        begin
            if (a == ecrd_pkg::A_SOFT)
                v = {24'd0, soft_reg};
            else if (a >= ecrd_pkg::A_CM_LO && a <= ecrd_pkg::A_CM_HI)
            begin
                w = 3'((a - ecrd_pkg::A_CM_LO) >> 2);
                v = cmask[w];
            end
            else if (a >= ecrd_pkg::A_PM_LO && a <= ecrd_pkg::A_PM_HI)
            begin
                w = 3'((a - ecrd_pkg::A_PM_LO) >> 2);
                v = pmask[w];
            end
            else if (a >= ecrd_pkg::A_ERR_LO && a <= ecrd_pkg::A_ERR_HI)
            begin
                w = 3'((a - ecrd_pkg::A_ERR_LO) >> 2);
                v = errw[w];
                errw[w] = 32'd0;
            end
            else if (a == ecrd_pkg::A_TLO)
                v = {24'd0, tlo_line};
            else if (a == ecrd_pkg::A_THI)
                v = {24'd0, thi_line};
            else if (a == ecrd_pkg::A_FIFO)
            begin
                v = {24'd0, scan_pos};
                fc_level = 1'b0;
                errw[scan_pos[7:5]][scan_pos[4:0]] = 1'b0;
                cnt[scan_pos] = cnt[scan_pos] - 8'd1;
                ctl_ready = 1'b1;
                model_scan();
            end
        end
        return v;
    endfunction

    function automatic void predict_request(input logic [1:0] kind, input logic [7:0] ln,
                                            input logic lvl, input logic [11:0] a,
                                            input logic [31:0] wd);
        result_t r;
        logic [31:0] rd;
        fwd_lines.delete();
        fwd_over = 1'b0;
        hit_lo = 1'b0;
        hit_hi = 1'b0;
        rd = model_access(kind, ln, lvl, a, wd);
        r = '0;
        r.read_data = rd;
        r.fc_irq = fc_level;
        r.err_irq = 1'b0;
        for (int i = 0; i < 8; i++)
            if (errw[i] != 32'd0)
                r.err_irq = 1'b1;
        r.timer_lo_hit = hit_lo;
        r.timer_hi_hit = hit_hi;
        r.periph_overflow = fwd_over;
        foreach (fwd_lines[i])
        begin
            r.periph_valid = 1'b1;
            r.periph_event = fwd_lines[i];
            r.last = 1'b0;
            expected_results.push_back(r);
        end
        r.periph_valid = 1'b0;
        r.periph_event = 8'd0;
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    int  send_gap_pct;

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] kind, input logic [7:0] ln,
                                input logic lvl, input logic [11:0] a,
                                input logic [31:0] wd);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.event_line <= ln;
        req.level <= lvl;
        req.address <= a;
        req.write_data <= wd;
        predict_request(kind, ln, lvl, a, wd);
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic send_event(input logic [7:0] ln, input logic lvl);
        send_request(ecrd_pkg::KIND_EVENT, ln, lvl, 12'd0, $urandom());
    endtask

    task automatic write_reg(input logic [11:0] a, input logic [31:0] wd);
        send_request(ecrd_pkg::KIND_WRITE, 8'($urandom()), 1'($urandom()), a, wd);
    endtask

    task automatic read_reg(input logic [11:0] a);
        send_request(ecrd_pkg::KIND_READ, 8'($urandom()), 1'($urandom()), a, $urandom());
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (sys.rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.read_data, rsp.fc_irq, rsp.err_irq, rsp.timer_lo_hit,
                   rsp.timer_hi_hit, rsp.periph_valid, rsp.periph_event,
                   rsp.periph_overflow, rsp.last};
            if (expected_results.size() == 0)
                report_mismatch("result with none expected");
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.read_data !== exp_r.read_data)
                    report_mismatch($sformatf("read_data %h exp %h", got.read_data,
                                              exp_r.read_data));
                if (got.fc_irq !== exp_r.fc_irq)
                    report_mismatch($sformatf("fc_irq %b exp %b", got.fc_irq, exp_r.fc_irq));
                if (got.err_irq !== exp_r.err_irq)
                    report_mismatch($sformatf("err_irq %b exp %b", got.err_irq, exp_r.err_irq));
                if (got.timer_lo_hit !== exp_r.timer_lo_hit)
                    report_mismatch("timer_lo_hit");
                if (got.timer_hi_hit !== exp_r.timer_hi_hit)
                    report_mismatch("timer_hi_hit");
                if (got.periph_valid !== exp_r.periph_valid)
                    report_mismatch("periph_valid");
                if (got.periph_event !== exp_r.periph_event)
                    report_mismatch($sformatf("periph_event %0d exp %0d", got.periph_event,
                                              exp_r.periph_event));
                if (got.periph_overflow !== exp_r.periph_overflow)
                    report_mismatch("periph_overflow");
                if (got.last !== exp_r.last)
                    report_mismatch("last");
            end
        end
    end

    // result-side stalls
    initial
    begin
        rsp.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (rsp_stall_on && $urandom_range(99) < 20)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic test_registers();
        for (int i = 0; i < 8; i++)
        begin
            write_reg(ecrd_pkg::A_CM_LO + 12'(4 * i), 32'hFFFFFFFF);
            write_reg(ecrd_pkg::A_PM_LO + 12'(4 * i), (i == 5) ? 32'h0 : 32'hFFFFFFFF);
        end
        read_reg(ecrd_pkg::A_CM_LO);
        read_reg(ecrd_pkg::A_PM_HI);
        write_reg(ecrd_pkg::A_TLO, 32'hFFFFFF00);
        write_reg(ecrd_pkg::A_THI, 32'h000000FF);
        read_reg(ecrd_pkg::A_TLO);
        read_reg(ecrd_pkg::A_THI);
        write_reg(12'h024, 32'h12345678);
        read_reg(12'h024);
        read_reg(12'hFFF);
        write_reg(12'hFFF, 32'hFFFFFFFF);
        send_request(KIND_BAD, 8'hFF, 1'b1, 12'hFFF, 32'hFFFFFFFF);
    endtask

    task automatic test_events();
        send_event(8'd0, 1'b1);
        send_event(8'd255, 1'b1);
        repeat (4) send_event(8'd7, 1'b1);
        send_event(8'd7, 1'b0);
        read_reg(ecrd_pkg::A_ERR_LO);
        read_reg(ecrd_pkg::A_ERR_HI);
        write_reg(ecrd_pkg::A_SOFT, 32'hFFFFFFFF);
        read_reg(ecrd_pkg::A_SOFT);
        write_reg(ecrd_pkg::A_CM_LO, 32'h0000_0080);
        send_event(8'd7, 1'b1);
        read_reg(ecrd_pkg::A_FIFO);
        read_reg(ecrd_pkg::A_FIFO);
        write_reg(ecrd_pkg::A_CM_LO, 32'h0000_0000);
        send_event(8'd3, 1'b1);
        read_reg(ecrd_pkg::A_FIFO);
    endtask

    function automatic logic [11:0] pick_address();
        case ($urandom_range(7))
            0: return ecrd_pkg::A_SOFT;
            1: return ecrd_pkg::A_CM_LO + 12'(4 * $urandom_range(7));
            2: return ecrd_pkg::A_PM_LO + 12'(4 * $urandom_range(7));
            3: return ecrd_pkg::A_ERR_LO + 12'(4 * $urandom_range(7));
            4: return ($urandom_range(1)) ? ecrd_pkg::A_TLO : ecrd_pkg::A_THI;
            5: return ecrd_pkg::A_FIFO;
            6: return 12'($urandom());
            default: return 12'h024 + 12'(4 * $urandom_range(7));
        endcase
    endfunction

    task automatic test_random(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_event(($urandom_range(3) == 0) ? 8'($urandom()) :
                           8'($urandom_range(0, 31) + 32 * $urandom_range(7)),
                           $urandom_range(9) != 0);
            else if (r < 60)
                read_reg(ecrd_pkg::A_FIFO);
            else if (r < 80)
                write_reg(pick_address(), ($urandom_range(3) == 0) ? 32'($urandom()) :
                          ~(32'h1 << $urandom_range(31)));
            else if (r < 97)
                read_reg(pick_address());
            else
                send_request(KIND_BAD, 8'($urandom()), 1'($urandom()), 12'($urandom()),
                             $urandom());
        end
    endtask

    initial
    begin
        mismatches = 0;
        rsp_stall_on = 1'b0;
        send_gap_pct = 0;
        req.valid = 1'b0;
        req.kind = ecrd_pkg::KIND_EVENT;
        req.event_line = 8'd0;
        req.level = 1'b0;
        req.address = 12'd0;
        req.write_data = 32'd0;
        model_reset();
        sys.rst_n = 1'b0;
        repeat (9) @(negedge clk);
        sys.rst_n = 1'b1;
        @(negedge clk);
        test_registers();
        test_events();
        wait_drained();
        send_gap_pct = 30;
        rsp_stall_on = 1'b1;
        test_random(150);
        wait_drained();
        test_random(100);
        send_gap_pct = 0;
        rsp_stall_on = 1'b0;
        test_random(50);
        wait_drained();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
